@@ rtl/core/stereo_comb_allpass_reverb_top_macros.svh @@
// ----------------------------------------------------------------------------
// Reverb assertion macros
// Shared concurrent assertion forms for the reverb checker.
// ----------------------------------------------------------------------------
`ifndef STEREO_COMB_ALLPASS_REVERB_TOP_MACROS_SVH
`define STEREO_COMB_ALLPASS_REVERB_TOP_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define SCAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a signal holds while the output word is stalled.
`define SCAR_ASSERT_HOLD(lbl, sig, msg) \
  `SCAR_ASSERT(lbl, (m_axis_tvalid && !m_axis_tready) |=> $stable(sig), msg)

`endif

@@ rtl/core/scar_pkg.sv @@
// ----------------------------------------------------------------------------
// Reverb package
// Sizes, constants, sequencer states and helpers shared by the reverb core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scar_pkg;

  localparam int PreDepth   = 8192;
  localparam int PreAw      = 13;
  localparam int CombDepth  = 2048;
  localparam int CombIw     = 11;
  localparam int CombAw     = 13;
  localparam int ApAw       = 10;
  localparam int ApDepth    = 1024;
  localparam int ApIw       = 10;

  localparam logic [11:0] COMB_SPREAD  = 12'd23;
  localparam logic [11:0] COMB_LEN_MIN = 12'd16;
  localparam logic [11:0] COMB_LEN_MAX = 12'd2025;
  localparam logic [9:0]  AP_SPREAD    = 10'd13;
  localparam logic [9:0]  AP_LEN_FIRST = 10'd556;
  localparam logic [9:0]  AP_LEN_SECOND = 10'd441;

  localparam logic [16:0] GAIN_BASE  = 17'd32768;
  localparam logic [14:0] GAIN_DECAY = 15'd29491;
  localparam logic [16:0] MIX_ONE    = 17'd65536;

  localparam logic [2:0] CFG_DECAY    = 3'd0;
  localparam logic [2:0] CFG_PREDELAY = 3'd1;
  localparam logic [2:0] CFG_MIX      = 3'd2;
  localparam logic [2:0] CFG_COMB0    = 3'd3;
  localparam logic [2:0] CFG_COMB1    = 3'd4;
  localparam logic [2:0] CFG_COMB2    = 3'd5;
  localparam logic [2:0] CFG_COMB3    = 3'd6;

  typedef enum logic [13:0] {
    ST_CLEAR = 14'b00000000000001,
    ST_IDLE  = 14'b00000000000010,
    ST_PRE   = 14'b00000000000100,
    ST_PRE_D = 14'b00000000001000,
    ST_C_RD  = 14'b00000000010000,
    ST_C_MUL = 14'b00000000100000,
    ST_C_WR  = 14'b00000001000000,
    ST_SUM   = 14'b00000010000000,
    ST_AP_RD = 14'b00000100000000,
    ST_AP_W  = 14'b00001000000000,
    ST_AP_O  = 14'b00010000000000,
    ST_MIX1  = 14'b00100000000000,
    ST_MIX2  = 14'b01000000000000,
    ST_DONE  = 14'b10000000000000
  } state_e;

  typedef struct packed {
    state_e             st;
    logic [1:0]         k;
    logic               sec;
    logic [PreAw-1:0]   clr_addr;
    logic [PreAw-1:0]   pre_wa;
    logic [PreAw-1:0]   pre_ra;
    logic               pre_fwd;
    logic [16:0]        gain;
    logic [16:0]        mix;
  } ctrl_t;

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    if (v > 28'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -28'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [26:0] v);
    if (v > 27'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -27'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

@@ rtl/core/scar_chan.sv @@
// ----------------------------------------------------------------------------
// Reverb channel
// Predelay, comb and allpass memories of one channel with their datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scar_chan (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  scar_pkg::ctrl_t        ctrl_i,
  input  logic                   is_right_i,
  input  logic [3:0][10:0]       comb_len_i,
  input  logic signed [15:0]     x_i,
  output logic signed [15:0]     y_o
);

  logic signed [15:0] pre_mem [scar_pkg::PreDepth];
  logic signed [23:0] comb_mem [4*scar_pkg::CombDepth];
  logic signed [23:0] ap_mem [scar_pkg::ApDepth];

  logic signed [15:0] pre_rd_q;
  logic signed [23:0] comb_rd_q;
  logic signed [23:0] ap_rd_q;

  logic [3:0][scar_pkg::CombIw-1:0] comb_idx_q;
  logic [1:0][scar_pkg::ApIw-1:0]   ap_idx_q;

  logic signed [15:0] pl_q;
  logic signed [23:0] y_q;
  logic signed [41:0] prod_q;
  logic signed [25:0] sum_q;
  logic signed [23:0] d_q;
  logic signed [23:0] a_q;
  logic signed [23:0] w_q;
  logic signed [33:0] p_dry_q;
  logic signed [41:0] p_wet_q;
  logic signed [15:0] out_q;

  logic                      clr;
  logic [11:0]               len_sel;
  logic [11:0]               comb_len;
  logic [scar_pkg::CombIw-1:0] il;
  logic [11:0]               il_nxt;
  logic [scar_pkg::CombAw-1:0] comb_addr;
  logic [41:0]               prod_rnd;
  logic signed [23:0]        comb_wr;
  logic [9:0]                ap_len;
  logic [9:0]                ap_off;
  logic [9:0]                ap_p;
  logic [10:0]               ap_nxt;
  logic [scar_pkg::ApAw-1:0] ap_addr;
  logic signed [24:0]        a_half;
  logic signed [23:0]        ap_w;
  logic signed [26:0]        ap_t;
  logic signed [25:0]        sum_r;
  logic signed [42:0]        mix_acc;

  assign clr = (ctrl_i.st == scar_pkg::ST_CLEAR);

  // Comb length of the selected line, held inside the usable range.
  always_comb begin
    len_sel = {1'b0, comb_len_i[ctrl_i.k]};
    if (len_sel < scar_pkg::COMB_LEN_MIN) begin
      len_sel = scar_pkg::COMB_LEN_MIN;
    end else if (len_sel > scar_pkg::COMB_LEN_MAX) begin
      len_sel = scar_pkg::COMB_LEN_MAX;
    end
    comb_len = is_right_i ? len_sel + scar_pkg::COMB_SPREAD : len_sel;
  end

  assign il        = comb_idx_q[ctrl_i.k];
  assign il_nxt    = {1'b0, il} + 12'd1;
  assign comb_addr = {ctrl_i.k, il};
  assign prod_rnd  = prod_q + 42'sd32768;
  assign comb_wr   = scar_pkg::sat24(28'(pl_q) + 28'($signed(prod_rnd[41:16])));

  // Allpass region of the current section.
  always_comb begin
    if (ctrl_i.sec) begin
      ap_len = scar_pkg::AP_LEN_SECOND + (is_right_i ? scar_pkg::AP_SPREAD : 10'd0);
      ap_off = scar_pkg::AP_LEN_FIRST + (is_right_i ? scar_pkg::AP_SPREAD : 10'd0);
    end else begin
      ap_len = scar_pkg::AP_LEN_FIRST + (is_right_i ? scar_pkg::AP_SPREAD : 10'd0);
      ap_off = 10'd0;
    end
    ap_p = (ap_idx_q[ctrl_i.sec] >= ap_len) ? 10'd0 : ap_idx_q[ctrl_i.sec];
  end

  assign ap_nxt  = {1'b0, ap_p} + 11'd1;
  assign ap_addr = ap_off + ap_p;
  assign a_half  = (25'(ap_rd_q) + 25'sd1) >>> 1;
  assign ap_w    = scar_pkg::sat24(28'(d_q) + 28'(a_half));
  assign ap_t    = (27'(a_q) <<< 1) - 27'(w_q) + 27'sd1;
  assign sum_r   = sum_q + 26'sd2;
  assign mix_acc = 43'(p_dry_q) + 43'(p_wet_q) + 43'sd32768;

  // Memories: clearing pass writes zeros, otherwise read-modify-write.
  always_ff @(posedge clk_i) begin
    if (clr) begin
      pre_mem[ctrl_i.clr_addr] <= '0;
    end else if (ctrl_i.st == scar_pkg::ST_PRE) begin
      pre_mem[ctrl_i.pre_wa] <= x_i;
    end
    pre_rd_q <= pre_mem[ctrl_i.pre_ra];
  end

  always_ff @(posedge clk_i) begin
    if (clr) begin
      comb_mem[ctrl_i.clr_addr] <= '0;
    end else if (ctrl_i.st == scar_pkg::ST_C_WR) begin
      comb_mem[comb_addr] <= comb_wr;
    end
    comb_rd_q <= comb_mem[comb_addr];
  end

  always_ff @(posedge clk_i) begin
    if (clr) begin
      ap_mem[ctrl_i.clr_addr[scar_pkg::ApAw-1:0]] <= '0;
    end else if (ctrl_i.st == scar_pkg::ST_AP_W) begin
      ap_mem[ap_addr] <= ap_w;
    end
    ap_rd_q <= ap_mem[ap_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comb_idx_q <= '0;
      ap_idx_q   <= '0;
    end else begin
      if (ctrl_i.st == scar_pkg::ST_C_WR) begin
        comb_idx_q[ctrl_i.k] <= (il_nxt >= comb_len) ? '0 : il_nxt[scar_pkg::CombIw-1:0];
      end
      if (ctrl_i.st == scar_pkg::ST_AP_W) begin
        ap_idx_q[ctrl_i.sec] <= (ap_nxt >= {1'b0, ap_len}) ? '0 : ap_nxt[scar_pkg::ApIw-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.st)
      scar_pkg::ST_PRE_D: begin
        pl_q  <= ctrl_i.pre_fwd ? x_i : pre_rd_q;
        sum_q <= '0;
      end
      scar_pkg::ST_C_MUL: begin
        y_q    <= comb_rd_q;
        prod_q <= comb_rd_q * $signed({1'b0, ctrl_i.gain});
      end
      scar_pkg::ST_C_WR: sum_q <= sum_q + 26'(y_q);
      scar_pkg::ST_SUM:  d_q   <= sum_r[25:2];
      scar_pkg::ST_AP_W: begin
        a_q <= ap_rd_q;
        w_q <= ap_w;
      end
      scar_pkg::ST_AP_O: d_q <= scar_pkg::sat24(28'($signed(ap_t[26:1])));
      scar_pkg::ST_MIX1: begin
        p_dry_q <= x_i * $signed({1'b0, scar_pkg::MIX_ONE - ctrl_i.mix});
        p_wet_q <= d_q * $signed({1'b0, ctrl_i.mix});
      end
      scar_pkg::ST_MIX2: out_q <= scar_pkg::sat16(mix_acc[42:16]);
      default: ;
    endcase
  end

  assign y_o = out_q;

endmodule

@@ rtl/core/stereo_comb_allpass_reverb_top.sv @@
// ----------------------------------------------------------------------------
// Stereo comb/allpass reverb
// Schroeder-style stereo reverb with predelay, four combs and two allpasses.
// ----------------------------------------------------------------------------
// One input word carries a stereo Q1.15 pair; one output word returns the
// mixed pair. After reset the core sweeps all delay memories to zero, one
// entry per cycle, and accepts no word until that is done. A word taken
// while the mix is zero passes straight through with no state change; any
// other word is worked by a sequencer that walks each channel's delay
// memories: predelay write and read, then read, multiply and write for
// each comb line, the comb sum, read, write and output for each allpass
// section, the mix products and their sum, and the output load. The next
// word is taken once the current result sits in the output register, so
// the core takes no new word while one is still in work. Configuration
// writes are taken at any time and must only land while the core is idle.
`timescale 1ns / 1ps

module stereo_comb_allpass_reverb_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] left_in, [31:16] right_in
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [15:0] left_out, [31:16] right_out
);

  scar_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [15:0]      decay_q;
  logic [12:0]      predelay_q;
  logic [16:0]      mix_q;
  logic [3:0][10:0] comb_len_q;

  // Sequencer registers.
  logic [scar_pkg::PreAw-1:0] clr_cnt_q;
  logic [scar_pkg::PreAw-1:0] wi_q;
  logic [1:0]                 k_q;
  logic                       sec_q;
  logic [16:0]                gain_q;
  logic                       bypass_q;
  logic signed [15:0]         xl_q, xr_q;

  // Output register.
  logic        out_valid_q;
  logic [31:0] out_data_q;

  logic              in_acc;
  logic              cfg_acc;
  logic              out_load;
  logic [31:0]       decay_prod;
  logic [16:0]       gain_d;
  logic [16:0]       mix_eff;
  logic signed [15:0] yl, yr;
  scar_pkg::ctrl_t   ctrl;

  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i & cfg_ready_o;
  assign s_axis_tready = (state_q == scar_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_load      = (state_q == scar_pkg::ST_DONE) & (~out_valid_q | m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Feedback gain: 0.5 + 0.45 * decay, rounded half up.
  assign decay_prod = 32'(decay_q) * 32'(scar_pkg::GAIN_DECAY) + 32'd32768;
  assign gain_d     = scar_pkg::GAIN_BASE + 17'(decay_prod[31:16]);
  // Mix above one acts as one.
  assign mix_eff    = (mix_q > scar_pkg::MIX_ONE) ? scar_pkg::MIX_ONE : mix_q;

  // Config decode; an index past the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q    <= 16'd32768;
      predelay_q <= '0;
      mix_q      <= '0;
      comb_len_q <= {11'd1966, 11'd1660, 11'd1366, 11'd1116};
    end else if (cfg_acc) begin
      unique case (cfg_index_i)
        scar_pkg::CFG_DECAY:    decay_q       <= cfg_data_i[15:0];
        scar_pkg::CFG_PREDELAY: predelay_q    <= cfg_data_i[12:0];
        scar_pkg::CFG_MIX:      mix_q         <= cfg_data_i;
        scar_pkg::CFG_COMB0:    comb_len_q[0] <= cfg_data_i[10:0];
        scar_pkg::CFG_COMB1:    comb_len_q[1] <= cfg_data_i[10:0];
        scar_pkg::CFG_COMB2:    comb_len_q[2] <= cfg_data_i[10:0];
        scar_pkg::CFG_COMB3:    comb_len_q[3] <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // Sequencer: clear, then per word predelay, four combs, two allpasses, mix; bypass words go straight to output.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scar_pkg::ST_CLEAR: if (&clr_cnt_q) state_d = scar_pkg::ST_IDLE;
      scar_pkg::ST_IDLE: begin
        if (in_acc) state_d = (mix_q == '0) ? scar_pkg::ST_DONE : scar_pkg::ST_PRE;
      end
      scar_pkg::ST_PRE:   state_d = scar_pkg::ST_PRE_D;
      scar_pkg::ST_PRE_D: state_d = scar_pkg::ST_C_RD;
      scar_pkg::ST_C_RD:  state_d = scar_pkg::ST_C_MUL;
      scar_pkg::ST_C_MUL: state_d = scar_pkg::ST_C_WR;
      scar_pkg::ST_C_WR:  state_d = (&k_q) ? scar_pkg::ST_SUM : scar_pkg::ST_C_RD;
      scar_pkg::ST_SUM:   state_d = scar_pkg::ST_AP_RD;
      scar_pkg::ST_AP_RD: state_d = scar_pkg::ST_AP_W;
      scar_pkg::ST_AP_W:  state_d = scar_pkg::ST_AP_O;
      scar_pkg::ST_AP_O:  state_d = sec_q ? scar_pkg::ST_MIX1 : scar_pkg::ST_AP_RD;
      scar_pkg::ST_MIX1:  state_d = scar_pkg::ST_MIX2;
      scar_pkg::ST_MIX2:  state_d = scar_pkg::ST_DONE;
      scar_pkg::ST_DONE:  if (out_load) state_d = scar_pkg::ST_IDLE;
      default:            state_d = scar_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scar_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      wi_q        <= '0;
      k_q         <= '0;
      sec_q       <= 1'b0;
      bypass_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == scar_pkg::ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (in_acc) begin
        bypass_q <= (mix_q == '0);
        k_q      <= '0;
        sec_q    <= 1'b0;
      end
      // Advance the predelay write pointer once the sample is stored.
      if (state_q == scar_pkg::ST_PRE_D) wi_q <= wi_q + 1'b1;
      if (state_q == scar_pkg::ST_C_WR) k_q <= k_q + 1'b1;
      if (state_q == scar_pkg::ST_AP_O) sec_q <= 1'b1;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the accepted pair and the gain for the whole sequence.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      xl_q   <= s_axis_tdata[15:0];
      xr_q   <= s_axis_tdata[31:16];
      gain_q <= gain_d;
    end
    if (out_load) begin
      out_data_q <= bypass_q ? {xr_q, xl_q} : {yr, yl};
    end
  end

  always_comb begin
    ctrl.st       = state_q;
    ctrl.k        = k_q;
    ctrl.sec      = sec_q;
    ctrl.clr_addr = clr_cnt_q;
    ctrl.pre_wa   = wi_q;
    ctrl.pre_ra   = wi_q - predelay_q;
    // Zero predelay reads the sample being written: forward it.
    ctrl.pre_fwd  = (predelay_q == '0);
    ctrl.gain     = gain_q;
    ctrl.mix      = mix_eff;
  end

  scar_chan u_chan_l (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .is_right_i (1'b0),
    .comb_len_i (comb_len_q),
    .x_i        (xl_q),
    .y_o        (yl)
  );

  scar_chan u_chan_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .is_right_i (1'b1),
    .comb_len_i (comb_len_q),
    .x_i        (xr_q),
    .y_o        (yr)
  );

endmodule

@@ rtl/core/scar_chk.sv @@
// ----------------------------------------------------------------------------
// Reverb port checker
// Watches the stream ports of the reverb top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stereo_comb_allpass_reverb_top_macros.svh"

module scar_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  `SCAR_ASSERT(a_out_valid_holds, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "out valid dropped")
  `SCAR_ASSERT_HOLD(a_out_data_holds, m_axis_tdata, "out data changed while stalled")
  `SCAR_ASSERT(a_one_word_at_a_time, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "second word taken while busy")
  `SCAR_ASSERT(a_result_after_work, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result appeared while idle")

endmodule

bind stereo_comb_allpass_reverb_top scar_chk u_scar_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Reverb core testbench
// Drives stereo words through the reverb under several register settings and
// checks every output word against a cycle-free fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Predictor and store of expected output pairs.
class reverb_scoreboard;
  int unsigned decay;
  int unsigned predelay;
  int unsigned mix;
  int unsigned comb_len[4];

  int pre_l[8192];
  int pre_r[8192];
  int unsigned pre_wi;
  int comb_l[8192];
  int comb_r[8192];
  int unsigned cidx_l[4];
  int unsigned cidx_r[4];
  int ap_l[1024];
  int ap_r[1024];
  int unsigned aidx_l[2];
  int unsigned aidx_r[2];

  logic [31:0] pending_pairs[$];
  int errors;
  int checked;

  function void clear();
    decay = 32768;
    predelay = 0;
    mix = 0;
    comb_len[0] = 1116;
    comb_len[1] = 1366;
    comb_len[2] = 1660;
    comb_len[3] = 1966;
    foreach (pre_l[i]) begin
      pre_l[i] = 0;
      pre_r[i] = 0;
      comb_l[i] = 0;
      comb_r[i] = 0;
    end
    foreach (ap_l[i]) begin
      ap_l[i] = 0;
      ap_r[i] = 0;
    end
    pre_wi = 0;
    for (int k = 0; k < 4; k++) begin
      cidx_l[k] = 0;
      cidx_r[k] = 0;
    end
    for (int k = 0; k < 2; k++) begin
      aidx_l[k] = 0;
      aidx_r[k] = 0;
    end
    errors = 0;
    checked = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [16:0] val);
    case (idx)
      scar_pkg::CFG_DECAY:    decay = 32'(val[15:0]);
      scar_pkg::CFG_PREDELAY: predelay = 32'(val[12:0]);
      scar_pkg::CFG_MIX:      mix = 32'(val);
      scar_pkg::CFG_COMB0:    comb_len[0] = 32'(val[10:0]);
      scar_pkg::CFG_COMB1:    comb_len[1] = 32'(val[10:0]);
      scar_pkg::CFG_COMB2:    comb_len[2] = 32'(val[10:0]);
      scar_pkg::CFG_COMB3:    comb_len[3] = 32'(val[10:0]);
      default: ;
    endcase
  endfunction

  // Round to nearest, ties up: add half, then floor.
  function longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function int clip(longint v, longint lo, longint hi);
    if (v < lo) return int'(lo);
    if (v > hi) return int'(hi);
    return int'(v);
  endfunction

  function int clip24(longint v);
    return clip(v, -8388608, 8388607);
  endfunction

  function int unsigned step_ptr(int unsigned p, int unsigned len);
    return (p + 1 >= len) ? 0 : p + 1;
  endfunction

  function int allpass_section(ref int mem[1024], ref int unsigned ptr,
                               input int unsigned base, int unsigned len, int x);
    int unsigned p;
    int a;
    int w;
    p = (ptr >= len) ? 0 : ptr;
    a = mem[base + p];
    w = clip24(longint'(x) + round_shift(a, 1));
    mem[base + p] = w;
    ptr = step_ptr(p, len);
    return clip24(round_shift(2 * longint'(a) - w, 1));
  endfunction

  function logic [15:0] blend(int dry, int wet, longint m);
    return 16'(clip(round_shift(longint'(dry) * (65536 - m) + longint'(wet) * m, 16),
                    -32768, 32767));
  endfunction

  // Note an accepted input word and queue the output pair it must produce.
  function void note_input(logic [31:0] word);
    int xl;
    int xr;
    int pl;
    int pr;
    int yl;
    int yr;
    int dl;
    int dr;
    int unsigned d;
    int unsigned ri;
    int unsigned len_l;
    int unsigned il;
    int unsigned ir;
    longint m;
    longint g;
    longint suml;
    longint sumr;
    xl = 32'($signed(word[15:0]));
    xr = 32'($signed(word[31:16]));
    if (mix == 0) begin
      pending_pairs.push_back(word);
      return;
    end
    m = (mix > 32'd65536) ? 64'd65536 : 64'(mix);
    d = predelay;
    pre_l[pre_wi] = xl;
    pre_r[pre_wi] = xr;
    ri = (pre_wi >= d) ? pre_wi - d : pre_wi + 8192 - d;
    pl = pre_l[ri];
    pr = pre_r[ri];
    pre_wi = step_ptr(pre_wi, 8192);
    g = 32768 + round_shift(longint'(decay) * 29491, 16);
    suml = 0;
    sumr = 0;
    for (int k = 0; k < 4; k++) begin
      len_l = comb_len[k];
      if (len_l < 16) len_l = 16;
      if (len_l > 2025) len_l = 2025;
      il = cidx_l[k];
      ir = cidx_r[k];
      yl = comb_l[k * 2048 + il];
      yr = comb_r[k * 2048 + ir];
      comb_l[k * 2048 + il] = clip24(longint'(pl) + round_shift(yl * g, 16));
      comb_r[k * 2048 + ir] = clip24(longint'(pr) + round_shift(yr * g, 16));
      suml += yl;
      sumr += yr;
      cidx_l[k] = step_ptr(il, len_l);
      cidx_r[k] = step_ptr(ir, len_l + 23);
    end
    dl = clip24(round_shift(suml, 2));
    dr = clip24(round_shift(sumr, 2));
    dl = allpass_section(ap_l, aidx_l[0], 0, 556, dl);
    dr = allpass_section(ap_r, aidx_r[0], 0, 569, dr);
    dl = allpass_section(ap_l, aidx_l[1], 556, 441, dl);
    dr = allpass_section(ap_r, aidx_r[1], 569, 454, dr);
    pending_pairs.push_back({blend(xr, dr, m), blend(xl, dl, m)});
  endfunction

  task report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %0s: got %0d expected %0d (word %0d)", what,
             $signed(got), $signed(want), checked);
    errors++;
  endtask

  task check_output(logic [31:0] word);
    logic [31:0] want;
    if (pending_pairs.size() == 0) begin
      $display("unexpected output word %h", word);
      errors++;
      return;
    end
    want = pending_pairs.pop_front();
    if (word[15:0] !== want[15:0]) report("left_out", word[15:0], want[15:0]);
    if (word[31:16] !== want[31:16]) report("right_out", word[31:16], want[31:16]);
    checked++;
  endtask
endclass

module testbench;

  localparam int IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [15:0] left_in, [31:16] right_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [15:0] left_out, [31:16] right_out

  reverb_scoreboard sb;
  bit  sink_stall_on = 1'b1;
  int  idle_cycles = 0;
  int  words_sent = 0;
  int  settings_run = 0;

  stereo_comb_allpass_reverb_top uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Check output words at the rising edge; count idle cycles for the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > IdleLimit) begin
        $display("watchdog: no progress, %0d words pending", sb.pending_pairs.size());
        $display("testbench failed");
        $finish;
      end
    end
  end

  // Receiver: stall at random about a quarter of the time, or not at all.
  always @(negedge clk_i) begin
    m_axis_tready <= sink_stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  task write_reg(logic [2:0] idx, logic [16:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drive one word, holding valid until it is taken.
  task send_word(logic [31:0] word, bit hold);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(word);
    words_sent++;
    if (!hold) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  // Bursts of random length with random gaps between them.
  task send_random(int count);
    int burst;
    logic [31:0] w;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && count > 0; i++) begin
        w = $urandom();
        if ($urandom_range(0, 7) == 0) w = {16'h8000, 16'h7FFF} ^ {32{w[0]}};
        send_word(w, (i < burst - 1) && (count > 1));
        count--;
      end
      repeat ($urandom_range(0, 30)) @(negedge clk_i);
    end
  endtask

  // Hold until every expected word has come, then let the core settle.
  task drain();
    while (sb.pending_pairs.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task apply_setting(logic [16:0] dec, logic [16:0] pre, logic [16:0] mx,
                     logic [16:0] c0, logic [16:0] c1, logic [16:0] c2, logic [16:0] c3);
    drain();
    write_reg(scar_pkg::CFG_DECAY, dec);
    write_reg(scar_pkg::CFG_PREDELAY, pre);
    write_reg(scar_pkg::CFG_MIX, mx);
    write_reg(scar_pkg::CFG_COMB0, c0);
    write_reg(scar_pkg::CFG_COMB1, c1);
    write_reg(scar_pkg::CFG_COMB2, c2);
    write_reg(scar_pkg::CFG_COMB3, c3);
    settings_run++;
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Bypass at reset settings: output equals input, no state change.
    send_word({16'h7FFF, 16'h8000}, 1'b0);
    send_word({16'h8000, 16'h7FFF}, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);

    // Full wet, zero predelay (sample returns straight), short combs, max decay.
    apply_setting(17'd65535, 17'd0, 17'd65536, 17'd16, 17'd17, 17'd20, 17'd31);
    send_word({16'h7FFF, 16'h7FFF}, 1'b0);
    for (int i = 0; i < 8; i++) send_word({16'h8000, 16'h8000}, 1'b1);
    send_word(32'h0001_FFFF, 1'b0);

    // Mix above one, predelay at the top of the store, lengths outside their range.
    apply_setting(17'd0, 17'd8191, 17'h1FFFF, 17'd0, 17'd2047, 17'd15, 17'd2026);
    for (int i = 0; i < 6; i++) send_word({16'h7FFF, 16'h8000}, 1'b0);

    // Shrink lengths while pointers sit past the new end.
    apply_setting(17'd40000, 17'd3, 17'd1, 17'd16, 17'd16, 17'd16, 17'd16);
    send_word(32'h1234_8765, 1'b0);

    sink_stall_on = 1'b0;
    apply_setting(17'd32768, 17'd5, 17'd32768, 17'd40, 17'd77, 17'd100, 17'd123);
    send_random(200);
    sink_stall_on = 1'b1;
    apply_setting(17'd65535, 17'd0, 17'd49152, 17'd16, 17'd2025, 17'd333, 17'd64);
    send_random(250);
    apply_setting(17'd12000, 17'd90, 17'd0, 17'd500, 17'd600, 17'd700, 17'd800);
    send_random(100);
    apply_setting(17'd0, 17'd1, 17'd65536, 17'd1116, 17'd1366, 17'd1660, 17'd1966);
    send_random(250);
    apply_setting(17'($urandom_range(0, 65535)), 17'($urandom_range(0, 8191)),
                  17'($urandom_range(1, 65536)), 17'd17, 17'd19, 17'd23, 17'd29);
    send_random(230);

    drain();
    $display("covered %0d words over %0d register settings, %0d output words checked",
             words_sent, settings_run + 1, sb.checked);
    if (sb.errors == 0 && sb.pending_pairs.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d errors, %0d words never arrived", sb.errors, sb.pending_pairs.size());
      $display("testbench failed");
    end
    $finish;
  end
endmodule
